>>> rtl/crt_pkg.sv
`default_nettype none

package crt_pkg;

    localparam int RESIDUE_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH       = 32;
    localparam int VALUE_WIDTH       = 64;

    localparam logic [VALUE_WIDTH-1:0] INT64_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_COPRIME = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_MODULUS_0 = 1'b0,
        REG_MODULUS_1 = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CLS_RUN,
        CLS_FAULT
    } item_class_t;

    typedef enum logic [3:0] {
        SU_IDLE,
        SU_LEN0,
        SU_LEN1,
        SU_MU0,
        SU_MU1,
        SU_MU2,
        SU_PROD,
        SU_EMOD,
        SU_EDIV,
        SU_EUPD,
        SU_FIX
    } setup_state_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] residue_0;
        logic [FIELD_WIDTH-1:0] residue_1;
    } operand_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]        canonical_value;
        logic signed [VALUE_WIDTH-1:0] centered_value;
        status_t                       status;
    } result_t;

    typedef struct packed {
        logic busy;
        logic inv_ok;
        logic wide;
    } setup_flags_t;

endpackage

`default_nettype wire

>>> rtl/crt_div.sv
`default_nettype none

module crt_div
    import crt_pkg::*;
#(
    parameter int W = RESIDUE_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2*W:0]     dividend,
    input  logic [W-1:0]     divisor,
    output logic             done,
    output logic [2*W:0]     quotient,
    output logic [W-1:0]     remainder
);

    localparam int DW = 2 * W + 1;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [CW-1:0] count_reg, count_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    trial_sub;

    // one quotient bit per cycle, restoring
    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign trial_sub = trial - {1'b0, divisor};

    always_comb
    begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quo_next   = dividend;
            rem_next   = '0;
            count_next = CW'(DW);
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial_sub[W-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/crt_setup.sv
`default_nettype none

module crt_setup
    import crt_pkg::*;
#(
    parameter int W = RESIDUE_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [0:0]               wr_index,
    input  logic [FIELD_WIDTH-1:0]   wr_data,
    output logic [W-1:0]             q0,
    output logic [W-1:0]             q1,
    output logic [W+1:0]             mu0,
    output logic [W+1:0]             mu1,
    output logic [W+1:0]             mu2,
    output logic [$clog2(W+1)-1:0]   l0,
    output logic [$clog2(W+1)-1:0]   l1,
    output logic [W-1:0]             inv,
    output logic [2*W-1:0]           product,
    output logic [2*W-1:0]           half,
    output setup_flags_t             flags
);

    localparam int LW = $clog2(W + 1);
    localparam int DW = 2 * W + 1;

    setup_state_t          state_reg, state_next;
    logic                  pending_reg;
    logic                  clr_pending;
    logic                  launched_reg, launched_next;
    logic                  ok_reg, ok_next;
    logic [W-1:0]          q0_reg, q1_reg;
    logic [W-1:0]          sh_reg, sh_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [LW-1:0]         l0_reg, l0_next, l1_reg, l1_next;
    logic [W+1:0]          mu0_reg, mu0_next, mu1_reg, mu1_next, mu2_reg, mu2_next;
    logic [2*W-1:0]        prod_reg, prod_next;
    logic [W-1:0]          inv_reg, inv_next;
    logic [W-1:0]          old_r_reg, old_r_next, r_reg, r_next;
    logic [W-1:0]          quo_reg, quo_next, tmp_reg, tmp_next;
    logic signed [W+1:0]   old_s_reg, old_s_next, s_reg, s_next;
    logic signed [2*W+2:0] qs;
    logic signed [W+1:0]   fix_v;
    logic signed [W+1:0]   q1_s;

    logic                  div_start;
    logic [DW-1:0]         div_dividend;
    logic [W-1:0]          div_divisor;
    logic                  div_done;
    logic [DW-1:0]         div_quo;
    logic [W-1:0]          div_rem;

    crt_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign qs    = $signed({1'b0, quo_reg}) * s_reg;
    assign q1_s  = $signed({2'b00, q1_reg});
    assign fix_v = old_s_reg[W+1] ? (old_s_reg + q1_s) : old_s_reg;

    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        ok_next       = ok_reg;
        clr_pending   = 1'b0;
        sh_next       = sh_reg;
        len_next      = len_reg;
        l0_next       = l0_reg;
        l1_next       = l1_reg;
        mu0_next      = mu0_reg;
        mu1_next      = mu1_reg;
        mu2_next      = mu2_reg;
        prod_next     = prod_reg;
        inv_next      = inv_reg;
        old_r_next    = old_r_reg;
        r_next        = r_reg;
        quo_next      = quo_reg;
        tmp_next      = tmp_reg;
        old_s_next    = old_s_reg;
        s_next        = s_reg;
        div_start     = 1'b0;
        div_dividend  = '0;
        div_divisor   = '0;
        unique case (state_reg)
            SU_IDLE:
            begin
                if (pending_reg)
                begin
                    clr_pending = 1'b1;
                    ok_next     = 1'b0;
                    if (q0_reg >= W'(2) && q1_reg >= W'(2))
                    begin
                        sh_next    = q0_reg;
                        len_next   = '0;
                        state_next = SU_LEN0;
                    end
                end
            end
            SU_LEN0:
            begin
                if (sh_reg != '0)
                begin
                    sh_next  = sh_reg >> 1;
                    len_next = len_reg + LW'(1);
                end
                else
                begin
                    l0_next    = len_reg;
                    sh_next    = q1_reg;
                    len_next   = '0;
                    state_next = SU_LEN1;
                end
            end
            SU_LEN1:
            begin
                if (sh_reg != '0)
                begin
                    sh_next  = sh_reg >> 1;
                    len_next = len_reg + LW'(1);
                end
                else
                begin
                    l1_next    = len_reg;
                    state_next = SU_MU0;
                end
            end
            SU_MU0:
            begin
                div_dividend = DW'(1) << (W + int'(l0_reg));
                div_divisor  = q0_reg;
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    mu0_next      = div_quo[W+1:0];
                    state_next    = SU_MU1;
                end
            end
            SU_MU1:
            begin
                div_dividend = DW'(1) << (W + int'(l1_reg));
                div_divisor  = q1_reg;
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    mu1_next      = div_quo[W+1:0];
                    state_next    = SU_MU2;
                end
            end
            SU_MU2:
            begin
                div_dividend = DW'(1) << (2 * int'(l1_reg));
                div_divisor  = q1_reg;
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    mu2_next      = div_quo[W+1:0];
                    state_next    = SU_PROD;
                end
            end
            SU_PROD:
            begin
                prod_next  = q0_reg * q1_reg;
                state_next = SU_EMOD;
            end
            SU_EMOD:
            begin
                div_dividend = DW'(q0_reg);
                div_divisor  = q1_reg;
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    old_r_next    = div_rem;
                    r_next        = q1_reg;
                    old_s_next    = (W+2)'(1);
                    s_next        = '0;
                    state_next    = SU_EDIV;
                end
            end
            SU_EDIV:
            begin
                div_dividend = DW'(old_r_reg);
                div_divisor  = r_reg;
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    quo_next      = div_quo[W-1:0];
                    tmp_next      = div_rem;
                    state_next    = SU_EUPD;
                end
            end
            SU_EUPD:
            begin
                old_r_next = r_reg;
                r_next     = tmp_reg;
                old_s_next = s_reg;
                s_next     = old_s_reg - qs[W+1:0];
                state_next = (tmp_reg == '0) ? SU_FIX : SU_EDIV;
            end
            SU_FIX:
            begin
                ok_next    = (old_r_reg == W'(1));
                inv_next   = (fix_v == q1_s) ? '0 : fix_v[W-1:0];
                state_next = SU_IDLE;
            end
            default:
            begin
                state_next = SU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SU_IDLE;
            pending_reg  <= 1'b1;
            launched_reg <= 1'b0;
            ok_reg       <= 1'b0;
            q0_reg       <= W'(2);
            q1_reg       <= W'(3);
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            ok_reg       <= ok_next;
            if (wr_en)
            begin
                pending_reg <= 1'b1;
                unique case (cfg_reg_t'(wr_index))
                    REG_MODULUS_0: q0_reg <= wr_data[W-1:0];
                    REG_MODULUS_1: q1_reg <= wr_data[W-1:0];
                    default:       q1_reg <= q1_reg;
                endcase
            end
            else if (clr_pending)
            begin
                pending_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        len_reg   <= len_next;
        l0_reg    <= l0_next;
        l1_reg    <= l1_next;
        mu0_reg   <= mu0_next;
        mu1_reg   <= mu1_next;
        mu2_reg   <= mu2_next;
        prod_reg  <= prod_next;
        inv_reg   <= inv_next;
        old_r_reg <= old_r_next;
        r_reg     <= r_next;
        quo_reg   <= quo_next;
        tmp_reg   <= tmp_next;
        old_s_reg <= old_s_next;
        s_reg     <= s_next;
    end

    assign q0      = q0_reg;
    assign q1      = q1_reg;
    assign mu0     = mu0_reg;
    assign mu1     = mu1_reg;
    assign mu2     = mu2_reg;
    assign l0      = l0_reg;
    assign l1      = l1_reg;
    assign inv     = inv_reg;
    assign product = prod_reg;
    assign half    = prod_reg >> 1;

    assign flags.busy   = pending_reg || (state_reg != SU_IDLE);
    assign flags.inv_ok = ok_reg;
    assign flags.wide   = (VALUE_WIDTH'(prod_reg) > INT64_TOP);

endmodule

`default_nettype wire

>>> rtl/crt_front.sv
`default_nettype none

module crt_front
    import crt_pkg::*;
#(
    parameter int W = RESIDUE_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  operand_t     operand,
    input  setup_flags_t flags,
    output logic         busy,
    output logic         head_valid,
    output item_class_t  head_cls,
    output logic [W-1:0] head_x0,
    output logic [W-1:0] head_x1
);

    localparam int QD = 2;
    localparam int QA = $clog2(QD);
    localparam int QC = $clog2(QD + 1);

    item_class_t   cls_q [QD];
    logic [W-1:0]  x0_q  [QD];
    logic [W-1:0]  x1_q  [QD];
    logic [QA-1:0] wp_reg, rp_reg;
    logic [QC-1:0] cnt_reg;
    logic          push, pop;

    // the back end drains one word every cycle, so pop whenever the head is live
    assign busy = flags.busy || (cnt_reg == QC'(QD));
    assign push = start && !busy;
    assign pop  = (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == QA'(QD - 1)) ? '0 : wp_reg + QA'(1);
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == QA'(QD - 1)) ? '0 : rp_reg + QA'(1);
            end
            cnt_reg <= cnt_reg + QC'(push) - QC'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cls_q[wp_reg] <= flags.inv_ok ? CLS_RUN : CLS_FAULT;
            x0_q[wp_reg]  <= operand.residue_0[W-1:0];
            x1_q[wp_reg]  <= operand.residue_1[W-1:0];
        end
    end

    assign head_valid = pop;
    assign head_cls   = cls_q[rp_reg];
    assign head_x0    = x0_q[rp_reg];
    assign head_x1    = x1_q[rp_reg];

endmodule

`default_nettype wire

>>> rtl/crt_back.sv
`default_nettype none

module crt_back
    import crt_pkg::*;
#(
    parameter int W = RESIDUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  item_class_t            in_cls,
    input  logic [W-1:0]           x0,
    input  logic [W-1:0]           x1,
    input  logic [W-1:0]           q0,
    input  logic [W-1:0]           q1,
    input  logic [W+1:0]           mu0,
    input  logic [W+1:0]           mu1,
    input  logic [W+1:0]           mu2,
    input  logic [$clog2(W+1)-1:0] l0,
    input  logic [$clog2(W+1)-1:0] l1,
    input  logic [W-1:0]           inv,
    input  logic [2*W-1:0]         product,
    input  logic [2*W-1:0]         half,
    input  logic                   wide,
    output logic                   done,
    output result_t                result
);

    localparam int NS = 15;

    logic [NS:1]     v_reg;
    item_class_t     cls_reg [1:NS-1];

    logic [W-1:0]    s1_x0, s1_x1;
    logic [2*W+1:0]  s1_p0, s1_p1;
    logic [W-1:0]    s2_x0, s2_x1;
    logic [W:0]      s2_t0, s2_t1;
    logic [W-1:0]    r0_reg [3:13];
    logic [W-1:0]    r1_reg [3:6];
    logic [2*W+1:0]  s4_p2;
    logic [W:0]      s5_t2;
    logic [W-1:0]    s6_r0m;
    logic [W-1:0]    s7_diff;
    logic [2*W-1:0]  s8_y;
    logic [2*W+2:0]  s9_z;
    logic [W+1:0]    s9_ylo, s10_ylo, s10_t;
    logic [W:0]      s11_r;
    logic [W-1:0]    s12_corr;
    logic [2*W-1:0]  s13_m, s14_val;
    result_t         result_reg, result_next;

    logic [2*W+1:0]  sh0, sh1, sh2;
    logic [2*W:0]    mt0, mt1, mt2;
    logic [W:0]      d0, d1, d2, red0, red1, red2;
    logic [W-1:0]    r0n, r1n, r0m_n;
    logic [W:0]      dd, dd_wrap;
    logic [2*W-1:0]  shy;
    logic [2*W+2:0]  shz;
    logic [2*W-1:0]  mt3;
    logic [W+1:0]    d3, red3;
    logic [W:0]      red4;

    // first reduction: x mod q with a precomputed reciprocal, one fix-up
    assign sh0  = s1_p0 >> (W + int'(l0));
    assign sh1  = s1_p1 >> (W + int'(l1));
    assign mt0  = sh0[W:0] * q0;
    assign mt1  = sh1[W:0] * q1;
    assign d0   = {1'b0, s2_x0} - s2_t0;
    assign d1   = {1'b0, s2_x1} - s2_t1;
    assign red0 = d0 - {1'b0, q0};
    assign red1 = d1 - {1'b0, q1};
    assign r0n  = (d0 >= {1'b0, q0}) ? red0[W-1:0] : d0[W-1:0];
    assign r1n  = (d1 >= {1'b0, q1}) ? red1[W-1:0] : d1[W-1:0];

    // r0 mod q1
    assign sh2   = s4_p2 >> (W + int'(l1));
    assign mt2   = sh2[W:0] * q1;
    assign d2    = {1'b0, r0_reg[5]} - s5_t2;
    assign red2  = d2 - {1'b0, q1};
    assign r0m_n = (d2 >= {1'b0, q1}) ? red2[W-1:0] : d2[W-1:0];

    // difference mod q1: wrap once when negative
    assign dd      = {1'b0, r1_reg[6]} - {1'b0, s6_r0m};
    assign dd_wrap = dd + {1'b0, q1};

    // (diff * inv) mod q1, classic reduction of a double-width word, two fix-ups
    assign shy  = s8_y >> (int'(l1) - 1);
    assign shz  = s9_z >> (int'(l1) + 1);
    assign mt3  = shz[W-1:0] * q1;
    assign d3   = s10_ylo - s10_t;
    assign red3 = d3 - {2'b00, q1};
    assign red4 = s11_r - {1'b0, q1};

    always_comb
    begin
        result_next = '0;
        if (cls_reg[14] == CLS_FAULT)
        begin
            result_next.status = ST_COPRIME;
        end
        else if (wide)
        begin
            result_next.canonical_value = VALUE_WIDTH'(s14_val);
            result_next.status          = ST_RANGE;
        end
        else
        begin
            result_next.canonical_value = VALUE_WIDTH'(s14_val);
            if (s14_val <= half)
            begin
                result_next.centered_value = VALUE_WIDTH'(s14_val);
            end
            else
            begin
                result_next.centered_value = VALUE_WIDTH'(s14_val) - VALUE_WIDTH'(product);
            end
            result_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[NS-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg[1] <= in_cls;
        for (int k = 2; k <= NS - 1; k++)
        begin
            cls_reg[k] <= cls_reg[k-1];
        end
        s1_x0 <= x0;
        s1_x1 <= x1;
        s1_p0 <= x0 * mu0;
        s1_p1 <= x1 * mu1;
        s2_x0 <= s1_x0;
        s2_x1 <= s1_x1;
        s2_t0 <= mt0[W:0];
        s2_t1 <= mt1[W:0];
        r0_reg[3] <= r0n;
        r1_reg[3] <= r1n;
        for (int k = 4; k <= 13; k++)
        begin
            r0_reg[k] <= r0_reg[k-1];
        end
        for (int k = 4; k <= 6; k++)
        begin
            r1_reg[k] <= r1_reg[k-1];
        end
        s4_p2    <= r0_reg[3] * mu1;
        s5_t2    <= mt2[W:0];
        s6_r0m   <= r0m_n;
        s7_diff  <= dd[W] ? dd_wrap[W-1:0] : dd[W-1:0];
        s8_y     <= s7_diff * inv;
        s9_z     <= shy[W:0] * mu2;
        s9_ylo   <= s8_y[W+1:0];
        s10_ylo  <= s9_ylo;
        s10_t    <= mt3[W+1:0];
        s11_r    <= (d3 >= {2'b00, q1}) ? red3[W:0] : d3[W:0];
        s12_corr <= (s11_r >= {1'b0, q1}) ? red4[W-1:0] : s11_r[W-1:0];
        s13_m    <= q0 * s12_corr;
        s14_val  <= s13_m + (2*W)'(r0_reg[13]);
        result_reg <= result_next;
    end

    assign done   = v_reg[NS];
    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/two_modulus_crt_reconstruct.sv
// Channel    Handshake          Payload                        Width
// ---------  -----------------  -----------------------------  -----
// operand    start / busy       residue_0, residue_1           2x32
// result     done (strobe)      canonical, centered, status    64+64+2
// config     wr_en, wr_index    wr_data (modulus_0/modulus_1)  32
//
// Accept one operand word per cycle unless busy is high: a word enters at an edge
// with start high and busy low, and its result word shows on result with done high.
// The receiver cannot stall; the output pipeline never holds, so done follows every
// accepted word.
// Reset and every config write start the setup sequencer, which holds busy high while
// it scans both modulus lengths, divides out three reciprocals, forms the product,
// then reduces q0 mod q1 by a fourth divide and runs Euclid steps for the inverse.

`default_nettype none

module two_modulus_crt_reconstruct
    import crt_pkg::*;
#(
    parameter int RESIDUE_WIDTH = RESIDUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  operand_t               operand,
    output logic                   busy,
    output logic                   done,
    output result_t                result,
    input  logic                   wr_en,
    input  logic [0:0]             wr_index,
    input  logic [FIELD_WIDTH-1:0] wr_data
);

    localparam int W  = RESIDUE_WIDTH;
    localparam int LW = $clog2(W + 1);

    // derived constants; user keeps stable while words are in flight, not enforced
    logic [W-1:0]   q0, q1, inv;
    logic [W+1:0]   mu0, mu1, mu2;
    logic [LW-1:0]  l0, l1;
    logic [2*W-1:0] product, half;
    setup_flags_t   flags;

    // front-to-back queue head
    logic           head_valid;
    item_class_t    head_cls;
    logic [W-1:0]   head_x0, head_x1;

    crt_setup #(.W(W)) u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .q0       (q0),
        .q1       (q1),
        .mu0      (mu0),
        .mu1      (mu1),
        .mu2      (mu2),
        .l0       (l0),
        .l1       (l1),
        .inv      (inv),
        .product  (product),
        .half     (half),
        .flags    (flags)
    );

    // accept and tag each word: run the arithmetic or flag the moduli as unusable
    crt_front #(.W(W)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operand    (operand),
        .flags      (flags),
        .busy       (busy),
        .head_valid (head_valid),
        .head_cls   (head_cls),
        .head_x0    (head_x0),
        .head_x1    (head_x1)
    );

    // Garner pipeline: reduce, difference, scale by the inverse, lift
    crt_back #(.W(W)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (head_valid),
        .in_cls   (head_cls),
        .x0       (head_x0),
        .x1       (head_x1),
        .q0       (q0),
        .q1       (q1),
        .mu0      (mu0),
        .mu1      (mu1),
        .mu2      (mu2),
        .l0       (l0),
        .l1       (l1),
        .inv      (inv),
        .product  (product),
        .half     (half),
        .wide     (flags.wide),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire

>>> rtl/crt_checker.sv
`default_nettype none

module crt_checker
    import crt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   busy,
    input logic                   done,
    input result_t                result,
    input logic                   wr_en
);

    // a config write always raises busy and requests a fresh derivation
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> busy)
        else $error("busy not raised after config write");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_COPRIME) |->
            (result.canonical_value == '0 && result.centered_value == '0))
        else $error("nonzero value with unusable moduli");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_RANGE) |-> (result.centered_value == '0))
        else $error("centered value given for oversized product");

    a_ok_lift: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_OK) |->
            (!result.canonical_value[63] &&
             ((result.centered_value == $signed(result.canonical_value)) ||
              result.centered_value[63])))
        else $error("centered lift inconsistent with canonical value");

endmodule

bind two_modulus_crt_reconstruct crt_checker u_crt_checker (.*);

`default_nettype wire
